// ===== rtl/core/crc8_packet_framer_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the packet framer core.
// Each macro guards its property with the asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef CRC8_PACKET_FRAMER_CORE_MACROS_SVH
`define CRC8_PACKET_FRAMER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cpf_pkg.sv =====
// ---------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and the CRC-8 byte update for the packet framer.
// ---------------------------------------------------------------------------
package cpf_pkg;

    localparam logic [7:0] CRC_POLY         = 8'h8C;
    localparam logic [7:0] CRC_INIT         = 8'h00;
    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'h55;

    // Register index as decoded from the word address.
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // One classified request as it travels from the front end to the serializer.
    typedef struct packed {
        logic       hdr;       // emit start marker, id and length first
        logic       has_data;  // emit the payload byte
        logic       trailer;   // emit CRC and end marker afterwards
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] crc;
    } entry_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } markers_t;

    // Reflected CRC-8 update over one byte, LSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] b;
        logic       fb;
        c = crc_in;
        b = data_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[0];
            c  = {1'b0, c[7:1]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            b = {1'b0, b[7:1]};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc8_packet_framer_core.sv =====
// ---------------------------------------------------------------------------
// crc8_packet_framer_core
// Framed packet builder with reflected CRC-8 (poly 0x8C, init 0x00).
// ---------------------------------------------------------------------------
// Each input request carries one payload byte together with the packet's
// message id and payload length. The first request of a packet produces the
// start marker, the id, the length and the payload byte; later requests
// produce only their payload byte, and the last one adds the CRC over the
// payload and the end marker, which is flagged by packet_end. A first request
// with length zero produces a whole empty packet (start, id, 0, CRC 0x00, end).
// The input side accepts one request per cycle as long as the request queue
// of QUEUE_DEPTH entries has room. The output side delivers one byte per
// cycle while pop is high and a request is queued, so the serializer sets
// the sustained rate: a packet's first request yields four output bytes (six
// for a one-byte packet, five for an empty one), a middle request one, and
// the last request three: n payload bytes make n + 5 output bytes. Markers are
// read from the registers when sent. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module crc8_packet_framer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input request channel.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  message_id,
    input  logic [7:0]  payload_length,
    // Result channel.
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        packet_end,
    // Configuration port: start marker at 0x0, end marker at 0x4.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpf_pkg::*;

    markers_t markers;
    entry_t   q_wr_entry;
    entry_t   q_head;
    logic     q_wr_en;
    logic     q_rd_en;
    logic     q_empty;

    // Marker registers.
    cpf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .markers (markers)
    );

    // The front end keeps the packet position and running CRC, so every
    // queued request already knows which bytes it must produce.
    cpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .q_full         (full),
        .payload_byte   (payload_byte),
        .message_id     (message_id),
        .payload_length (payload_length),
        .q_wr_en        (q_wr_en),
        .q_wr_entry     (q_wr_entry)
    );

    // The queue decouples input acceptance from byte-serial output.
    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_entry (q_wr_entry),
        .rd_en    (q_rd_en),
        .rd_entry (q_head),
        .full     (full),
        .empty    (q_empty)
    );

    // The serializer retires a queued request once its last byte is taken.
    cpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (q_head),
        .markers    (markers),
        .pop        (pop),
        .q_rd_en    (q_rd_en),
        .empty      (empty),
        .out_byte   (out_byte),
        .packet_end (packet_end)
    );

endmodule

// ===== rtl/core/cpf_regs.sv =====
// ---------------------------------------------------------------------------
// cpf_regs
// APB-style register file holding the start and end marker bytes.
// ---------------------------------------------------------------------------
module cpf_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cpf_pkg::markers_t markers
);
    import cpf_pkg::*;

    logic [7:0] start_marker_reg;
    logic [7:0] start_marker_next;
    logic [7:0] end_marker_reg;
    logic [7:0] end_marker_next;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb
    begin
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_START_MARKER: start_marker_next = pwdata[7:0];
                REG_END_MARKER:   end_marker_next   = pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_MARKER: prdata = {24'd0, start_marker_reg};
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign markers.start_marker = start_marker_reg;
    assign markers.end_marker   = end_marker_reg;

endmodule

// ===== rtl/core/cpf_front.sv =====
// ---------------------------------------------------------------------------
// cpf_front
// Accepts input requests, tracks packet position and the running CRC, and
// classifies each request into the bytes it must produce.
// ---------------------------------------------------------------------------
module cpf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            q_full,
    input  logic [7:0]      payload_byte,
    input  logic [7:0]      message_id,
    input  logic [7:0]      payload_length,
    output logic            q_wr_en,
    output cpf_pkg::entry_t q_wr_entry
);
    import cpf_pkg::*;

    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] running_crc_reg;
    logic [7:0] running_crc_next;
    logic       in_packet_reg;
    logic       in_packet_next;
    logic [7:0] crc_base;
    logic [7:0] crc_new;
    logic [7:0] left_base;
    logic [7:0] left_dec;

    assign q_wr_en   = push && !q_full;
    assign crc_base  = in_packet_reg ? running_crc_reg : CRC_INIT;
    assign crc_new   = crc8_update(crc_base, payload_byte);
    assign left_base = in_packet_reg ? bytes_left_reg : payload_length;
    assign left_dec  = left_base - 8'd1;

    always_comb
    begin
        q_wr_entry.hdr  = !in_packet_reg;
        q_wr_entry.id   = message_id;
        q_wr_entry.len  = payload_length;
        q_wr_entry.data = payload_byte;
        if (!in_packet_reg && (payload_length == 8'd0))
        begin
            // Empty packet: header, zero CRC and end marker in one request.
            q_wr_entry.has_data = 1'b0;
            q_wr_entry.trailer  = 1'b1;
            q_wr_entry.crc      = CRC_INIT;
            in_packet_next      = 1'b0;
            running_crc_next    = CRC_INIT;
            bytes_left_next     = 8'd0;
        end
        else
        begin
            q_wr_entry.has_data = 1'b1;
            q_wr_entry.crc      = crc_new;
            if (left_dec == 8'd0)
            begin
                q_wr_entry.trailer = 1'b1;
                in_packet_next     = 1'b0;
                running_crc_next   = CRC_INIT;
                bytes_left_next    = 8'd0;
            end
            else
            begin
                q_wr_entry.trailer = 1'b0;
                in_packet_next     = 1'b1;
                running_crc_next   = crc_new;
                bytes_left_next    = left_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= 8'd0;
            running_crc_reg <= CRC_INIT;
            in_packet_reg   <= 1'b0;
        end
        else if (q_wr_en)
        begin
            bytes_left_reg  <= bytes_left_next;
            running_crc_reg <= running_crc_next;
            in_packet_reg   <= in_packet_next;
        end
    end

endmodule

// ===== rtl/core/cpf_queue.sv =====
// ---------------------------------------------------------------------------
// cpf_queue
// Small request queue between the front end and the serializer.
// ---------------------------------------------------------------------------
`include "crc8_packet_framer_core_macros.svh"

module cpf_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  cpf_pkg::entry_t wr_entry,
    input  logic            rd_en,
    output cpf_pkg::entry_t rd_entry,
    output logic            full,
    output logic            empty
);
    import cpf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    entry_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CPF_ASSERT_NEXT(a_q_fill, clk, rst_n, do_wr && !do_rd, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on write")
    `CPF_ASSERT_NEXT(a_q_drain, clk, rst_n, do_rd && !do_wr, count_reg == $past(count_reg) - 1'b1, "queue count did not shrink on read")

endmodule

// ===== rtl/core/cpf_back.sv =====
// ---------------------------------------------------------------------------
// cpf_back
// Serializer: walks each queued request through its output bytes, one per
// accepted result.
// ---------------------------------------------------------------------------
`include "crc8_packet_framer_core_macros.svh"

module cpf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cpf_pkg::entry_t   head,
    input  cpf_pkg::markers_t markers,
    input  logic              pop,
    output logic              q_rd_en,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              packet_end
);
    import cpf_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CRC,
        PH_END
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   fresh_reg;
    phase_t cur_phase;
    logic   taken;
    logic   entry_done;

    assign cur_phase = fresh_reg ? (head.hdr ? PH_START : PH_DATA) : phase_reg;
    assign taken     = pop && !q_empty;
    assign empty     = q_empty;
    assign q_rd_en   = taken && entry_done;

    always_comb
    begin
        entry_done = 1'b0;
        phase_next = cur_phase;
        case (cur_phase)
            PH_START: phase_next = PH_ID;
            PH_ID:    phase_next = PH_LEN;
            PH_LEN:   phase_next = head.has_data ? PH_DATA : PH_CRC;
            PH_DATA:
            begin
                phase_next = PH_CRC;
                entry_done = !head.trailer;
            end
            PH_CRC:   phase_next = PH_END;
            PH_END:   entry_done = 1'b1;
            default:  entry_done = 1'b1;
        endcase
    end

    always_comb
    begin
        case (cur_phase)
            PH_START: out_byte = markers.start_marker;
            PH_ID:    out_byte = head.id;
            PH_LEN:   out_byte = head.len;
            PH_DATA:  out_byte = head.data;
            PH_CRC:   out_byte = head.crc;
            PH_END:   out_byte = markers.end_marker;
            default:  out_byte = 8'd0;
        endcase
    end

    assign packet_end = (cur_phase == PH_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            fresh_reg <= 1'b1;
        end
        else if (taken)
        begin
            phase_reg <= phase_next;
            fresh_reg <= entry_done;
        end
    end

    `CPF_ASSERT_SAME(a_end_has_trailer, clk, rst_n, !q_empty && packet_end, head.trailer, "end marker on a request without trailer")
    `CPF_ASSERT_NEXT(a_mid_keeps_head, clk, rst_n, taken && !entry_done, !q_empty && !fresh_reg, "request left the queue before its last byte")

endmodule
